// ===== design/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// shared constants and types for the lzss ring decompressor
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int RING_SIZE     = 4096;
    localparam int LONGEST_MATCH = 18;
    localparam int MATCH_FLOOR   = 2;

    localparam int RING_AW  = $clog2(RING_SIZE);
    localparam int FILL_W   = RING_AW + 1;
    localparam int SIZE_W   = 24;
    localparam int LEN_W    = $clog2(LONGEST_MATCH + 1);

    localparam logic [RING_AW-1:0] RESET_WP  = RING_AW'(RING_SIZE - LONGEST_MATCH);
    localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(RING_SIZE);
    localparam logic [LEN_W-1:0]   LEN_BIAS  = LEN_W'(MATCH_FLOOR + 1);
    localparam logic [7:0]         FILL_BYTE = 8'h20;
    localparam logic [7:0]         FLAG_MARK = 8'hFF;

    // parse position inside the token stream
    typedef enum logic [1:0] {
        PH_BOUNDARY = 2'd0,
        PH_TOKEN    = 2'd1,
        PH_REF      = 2'd2
    } phase_t;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       data_valid;
        logic       run_last;
        logic       complete;
        logic       short_input;
    } res_t;

endpackage

// ===== design/lzss_ring_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_ring_decompressor
// lzss decompressor over a 4096-byte history ring, one compressed byte a beat
// ----------------------------------------------------------------------------
// Takes one compressed byte per input beat and delivers decompressed bytes one
// per output beat. A flag byte gives no data output. A literal goes straight to
// the output and into the ring, with no ring read. A reference copies 3 to 18
// bytes from earlier in the ring to the output and back into it: every byte goes
// through the ring's read port as a registered read followed by the write-back,
// and that read/write pair sets the rate. in_stall stays high while an item
// is being worked on and while a result waits on out_stall. The ring needs no
// clearing pass after reset: a fill count marks which entries have been
// written, and the rest read as their reset value. Write output_size only
// while the block is idle; once the size is reached or in_last has been seen,
// further input is taken and dropped until reset.
module lzss_ring_decompressor
(
    input  logic                        clk,
    input  logic                        rst_n,
    // compressed input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_byte,
    input  logic                        in_last,
    // decompressed output
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic                        data_valid,
    output logic                        run_last,
    output logic                        complete,
    output logic                        short_input,
    // output size register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lzss_pkg::SIZE_W-1:0] cfg_data
);

    logic [lzss_pkg::SIZE_W-1:0]  size_reg;
    logic                         out_valid_reg;
    lzss_pkg::res_t               res_reg;

    logic                         ring_wr_en;
    logic [7:0]                   ring_wr_data;
    logic                         ring_rd_en;
    logic [lzss_pkg::RING_AW-1:0] ring_rd_addr;
    logic [7:0]                   ring_rd_data;
    logic                         res_ready;
    logic                         res_load;
    lzss_pkg::res_t               res;

    // size register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= lzss_pkg::SIZE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // history ring with its own write pointer
    lzss_ring u_ring
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr_en),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    // parser and copy sequencer
    lzss_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .in_stall     (in_stall),
        .output_size  (size_reg),
        .ring_wr_en   (ring_wr_en),
        .ring_wr_data (ring_wr_data),
        .ring_rd_en   (ring_rd_en),
        .ring_rd_addr (ring_rd_addr),
        .ring_rd_data (ring_rd_data),
        .res_ready    (res_ready),
        .res_load     (res_load),
        .res          (res)
    );

    // output register, loads when empty or when the held beat leaves
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = res_reg.out_byte;
    assign data_valid  = res_reg.data_valid;
    assign run_last    = res_reg.run_last;
    assign complete    = res_reg.complete;
    assign short_input = res_reg.short_input;

endmodule

// ===== design/lzss_ring.sv =====
// ----------------------------------------------------------------------------
// lzss_ring
// 4096-byte history ring, sequential writes, registered read, fill-count reset
// ----------------------------------------------------------------------------
module lzss_ring
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [lzss_pkg::RING_AW-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0]                   mem [lzss_pkg::RING_SIZE];
    logic [lzss_pkg::RING_AW-1:0] wp_reg;
    logic [lzss_pkg::FILL_W-1:0]  fill_reg;
    logic [7:0]                   q_reg;
    logic                         hit_reg;
    logic [7:0]                   dflt_reg;
    logic [lzss_pkg::RING_AW-1:0] rd_offset;

    // distance from the reset write position, entries below fill are written
    assign rd_offset = rd_addr - lzss_pkg::RESET_WP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= lzss_pkg::RESET_WP;
            fill_reg <= '0;
        end
        else if (wr_en)
        begin
            wp_reg <= wp_reg + 1'b1;
            if (fill_reg != lzss_pkg::FILL_FULL)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg    <= mem[rd_addr];
            hit_reg  <= ({1'b0, rd_offset} < fill_reg);
            dflt_reg <= (rd_addr >= lzss_pkg::RESET_WP) ? 8'h00 : lzss_pkg::FILL_BYTE;
        end
    end

    assign rd_data = hit_reg ? q_reg : dflt_reg;

endmodule

// ===== design/lzss_seq.sv =====
// ----------------------------------------------------------------------------
// lzss_seq
// token parser and copy sequencer, one ring byte per read/write step pair
// ----------------------------------------------------------------------------
module lzss_seq
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [7:0]                   in_byte,
    input  logic                         in_last,
    output logic                         in_stall,
    input  logic [lzss_pkg::SIZE_W-1:0]  output_size,
    output logic                         ring_wr_en,
    output logic [7:0]                   ring_wr_data,
    output logic                         ring_rd_en,
    output logic [lzss_pkg::RING_AW-1:0] ring_rd_addr,
    input  logic [7:0]                   ring_rd_data,
    input  logic                         res_ready,
    output logic                         res_load,
    output lzss_pkg::res_t               res
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_STATUS = 4'b1000
    } state_t;

    state_t                       state_reg,    state_next;
    lzss_pkg::phase_t             phase_reg,    phase_next;
    logic [15:0]                  flag_reg,     flag_next;
    logic [7:0]                   held_reg,     held_next;
    logic [lzss_pkg::SIZE_W-1:0]  produced_reg, produced_next;
    logic                         finished_reg, finished_next;
    logic [lzss_pkg::RING_AW-1:0] addr_reg,     addr_next;
    logic [lzss_pkg::LEN_W-1:0]   rem_reg,      rem_next;
    logic [7:0]                   lit_reg,      lit_next;
    logic                         is_lit_reg,   is_lit_next;
    logic                         last_reg,     last_next;

    logic [lzss_pkg::SIZE_W-1:0]  prod_inc;
    logic                         hit_size;
    logic                         step_final;
    logic                         tok_bit;
    logic [7:0]                   cur_byte;

    assign prod_inc   = produced_reg + 1'b1;
    assign hit_size   = (prod_inc == output_size);
    assign step_final = (rem_reg == lzss_pkg::LEN_W'(1)) || hit_size;
    assign tok_bit    = (phase_reg == lzss_pkg::PH_TOKEN) ? flag_reg[0] : flag_reg[1];
    assign cur_byte   = is_lit_reg ? lit_reg : ring_rd_data;

    assign in_stall     = (state_reg != ST_IDLE);
    assign ring_rd_en   = (state_reg == ST_READ);
    assign ring_rd_addr = addr_reg;
    assign ring_wr_data = cur_byte;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        flag_next     = flag_reg;
        held_next     = held_reg;
        produced_next = produced_reg;
        finished_next = finished_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        lit_next      = lit_reg;
        is_lit_next   = is_lit_reg;
        last_next     = last_reg;
        ring_wr_en    = 1'b0;
        res_load      = 1'b0;
        res           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !finished_reg && (produced_reg < output_size))
                begin
                    last_next = in_last;
                    if (phase_reg == lzss_pkg::PH_REF)
                    begin
                        addr_next   = {in_byte[7:4], held_reg};
                        rem_next    = {1'b0, in_byte[3:0]} + lzss_pkg::LEN_BIAS;
                        is_lit_next = 1'b0;
                        phase_next  = lzss_pkg::PH_BOUNDARY;
                        state_next  = ST_READ;
                    end
                    else if (phase_reg == lzss_pkg::PH_BOUNDARY && !flag_reg[9])
                    begin
                        // flag byte, eight token bits with a stop mark above
                        flag_next  = {lzss_pkg::FLAG_MARK, in_byte};
                        phase_next = lzss_pkg::PH_TOKEN;
                        if (in_last)
                        begin
                            state_next = ST_STATUS;
                        end
                    end
                    else
                    begin
                        if (phase_reg == lzss_pkg::PH_BOUNDARY)
                        begin
                            flag_next = {1'b0, flag_reg[15:1]};
                        end
                        if (tok_bit)
                        begin
                            lit_next    = in_byte;
                            is_lit_next = 1'b1;
                            rem_next    = lzss_pkg::LEN_W'(1);
                            phase_next  = lzss_pkg::PH_BOUNDARY;
                            state_next  = ST_WRITE;
                        end
                        else
                        begin
                            held_next  = in_byte;
                            phase_next = lzss_pkg::PH_REF;
                            if (in_last)
                            begin
                                state_next = ST_STATUS;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (res_ready)
                begin
                    res_load         = 1'b1;
                    ring_wr_en       = 1'b1;
                    res.out_byte     = cur_byte;
                    res.data_valid   = 1'b1;
                    res.run_last     = step_final;
                    res.complete     = hit_size;
                    res.short_input  = step_final && last_reg && !hit_size;
                    produced_next    = prod_inc;
                    rem_next         = rem_reg - 1'b1;
                    addr_next        = addr_reg + 1'b1;
                    if (step_final)
                    begin
                        finished_next = hit_size || last_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_STATUS:
            begin
                if (res_ready)
                begin
                    res_load        = 1'b1;
                    res.run_last    = 1'b1;
                    res.short_input = 1'b1;
                    finished_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= lzss_pkg::PH_BOUNDARY;
            flag_reg     <= '0;
            held_reg     <= '0;
            produced_reg <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            flag_reg     <= flag_next;
            held_reg     <= held_next;
            produced_reg <= produced_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        rem_reg    <= rem_next;
        lit_reg    <= lit_next;
        is_lit_reg <= is_lit_next;
        last_reg   <= last_next;
    end

endmodule
